// File: hw/rtl/bdq_pkg.sv
`timescale 1ns / 1ps

package bdq_pkg;

  // operation codes on the kind port (code 7 is unused)
  typedef enum logic [2:0] {
    K_PUSH_FRONT = 3'd0,
    K_POP_FRONT  = 3'd1,
    K_PUSH_BACK  = 3'd2,
    K_POP_BACK   = 3'd3,
    K_READ       = 3'd4,
    K_WRITE      = 3'd5,
    K_FIND       = 3'd6
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  localparam int KIND_W   = 3;
  localparam int POS_W    = 8;
  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 9;

endpackage

// File: hw/rtl/bounded_deque_with_index_search.sv
`timescale 1ns / 1ps

// Bounded double-ended queue of DATA_WIDTH-bit words kept as a ring in one
// synchronous RAM (DEPTH entries, one read or one write per cycle).
//
// Command channel: a beat is taken at a rising edge with start high and busy
// low; kind, position and value are sampled there. Result channel: done is
// high for exactly one cycle and carries data_out, found, found_position,
// count and status. The receiver cannot stall; every command yields exactly
// one result beat.
//
// Result timing and command rate:
//   push, write, failed ops, unused kind: result the cycle after the beat,
//     busy stays low, so one command per cycle.
//   pop, read: the RAM read fills rd_data, the result follows from S_RD; busy in S_RD.
//   find: one RAM read per entry, scanning from the front until a hit or the
//     last entry, busy throughout; an empty queue is answered like a push.
// Reset (rst, synchronous): queue becomes empty, front at ring slot 0. RAM
// contents are not cleared; only written entries are ever read back.
module bounded_deque_with_index_search
  import bdq_pkg::*;
#(
  parameter int DEPTH      = 256,
  parameter int DATA_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [KIND_W-1:0]         kind,
  input  logic [POS_W-1:0]          position,
  input  logic signed [VALUE_W-1:0] value,
  output logic                      done,
  output logic signed [VALUE_W-1:0] data_out,
  output logic                      found,
  output logic [POS_W-1:0]          found_position,
  output logic [COUNT_W-1:0]        count,
  output logic [1:0]                status
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW:0]   DEPTH_W = (AW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_RD, S_SCAN} state_t;

  state_t                state;
  logic [AW-1:0]         front_pointer;
  logic [CW-1:0]         element_count;

  // ring storage
  logic [DATA_WIDTH-1:0] ring_mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data;

  // search context
  logic [DATA_WIDTH-1:0] key;
  logic [AW-1:0]         scan_addr;
  logic [CW-1:0]         scan_pos;   // position of the word now in rd_data

  logic [DATA_WIDTH-1:0] word_in;
  logic signed [VALUE_W-1:0] rd_ext;

  // value port to stored word, stored word to data_out port
  generate
    if (DATA_WIDTH <= VALUE_W) begin : g_narrow
      assign word_in = value[DATA_WIDTH-1:0];
      assign rd_ext  = VALUE_W'(signed'(rd_data));
    end else begin : g_wide
      assign word_in = DATA_WIDTH'(unsigned'(value));
      assign rd_ext  = rd_data[VALUE_W-1:0];
    end
  endgenerate

  // front + offset modulo DEPTH; front is below DEPTH, the offset at most DEPTH
  function automatic logic [AW-1:0] wrap(input logic [AW:0] s);
    logic [AW:0] d;
    d = s - DEPTH_W;
    return (s >= DEPTH_W) ? d[AW-1:0] : s[AW-1:0];
  endfunction

  logic          accept;
  logic          is_full, is_empty, pos_ok;
  logic [AW-1:0] front_dec, front_inc, slot_pos, slot_back, slot_last;

  assign accept   = start && !busy;
  assign is_full  = (element_count == DEPTH_C);
  assign is_empty = (element_count == '0);
  assign pos_ok   = (32'(position) < 32'(element_count));

  assign front_dec = (front_pointer == '0) ? AW'(DEPTH - 1) : front_pointer - AW'(1);
  assign front_inc = wrap({1'b0, front_pointer} + (AW + 1)'(1));
  assign slot_pos  = wrap({1'b0, front_pointer} + (AW + 1)'(position));
  assign slot_back = wrap({1'b0, front_pointer} + (AW + 1)'(element_count));
  assign slot_last = wrap({1'b0, front_pointer} + (AW + 1)'(element_count) - (AW + 1)'(1));

  // command decode at the accepting edge
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [AW-1:0] front_next;
  logic [CW-1:0] count_next;
  logic          go_rd, go_scan, imm;
  status_t       imm_status;

  // scan step
  logic          hit, last;

  assign hit  = (rd_data == key);
  assign last = ((scan_pos + CW'(1)) == element_count);

  always_comb begin
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    wr_addr    = slot_pos;
    rd_addr    = slot_pos;
    front_next = front_pointer;
    count_next = element_count;
    go_rd      = 1'b0;
    go_scan    = 1'b0;
    imm        = 1'b0;
    imm_status = ST_OK;
    if (state == S_IDLE && accept) begin
      imm = 1'b1;
      unique case (kind)
        K_PUSH_FRONT: begin
          if (is_full) begin
            imm_status = ST_FULL;
          end else begin
            wr_en      = 1'b1;
            wr_addr    = front_dec;
            front_next = front_dec;
            count_next = element_count + CW'(1);
          end
        end
        K_PUSH_BACK: begin
          if (is_full) begin
            imm_status = ST_FULL;
          end else begin
            wr_en      = 1'b1;
            wr_addr    = slot_back;
            count_next = element_count + CW'(1);
          end
        end
        K_POP_FRONT: begin
          if (is_empty) begin
            imm_status = ST_EMPTY;
          end else begin
            imm        = 1'b0;
            go_rd      = 1'b1;
            rd_en      = 1'b1;
            rd_addr    = front_pointer;
            front_next = front_inc;
            count_next = element_count - CW'(1);
          end
        end
        K_POP_BACK: begin
          if (is_empty) begin
            imm_status = ST_EMPTY;
          end else begin
            imm        = 1'b0;
            go_rd      = 1'b1;
            rd_en      = 1'b1;
            rd_addr    = slot_last;
            count_next = element_count - CW'(1);
          end
        end
        K_READ: begin
          if (!pos_ok) begin
            imm_status = ST_RANGE;
          end else begin
            imm   = 1'b0;
            go_rd = 1'b1;
            rd_en = 1'b1;
          end
        end
        K_WRITE: begin
          if (!pos_ok) begin
            imm_status = ST_RANGE;
          end else begin
            wr_en = 1'b1;
          end
        end
        K_FIND: begin
          if (!is_empty) begin
            imm     = 1'b0;
            go_scan = 1'b1;
            rd_en   = 1'b1;
            rd_addr = front_pointer;
          end
        end
        default: begin
        end
      endcase
    end else if (state == S_SCAN && !hit && !last) begin
      rd_en   = 1'b1;
      rd_addr = scan_addr;
    end
  end

  // RAM: one port, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_mem[wr_addr] <= word_in;
    end
    if (rd_en) begin
      rd_data <= ring_mem[rd_addr];
    end
  end

  // control, search context and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      front_pointer <= '0;
      element_count <= '0;
      done          <= 1'b0;
    end else begin
      done          <= 1'b0;
      front_pointer <= front_next;
      element_count <= count_next;
      unique case (state)
        S_IDLE: begin
          if (imm) begin
            done           <= 1'b1;
            data_out       <= '0;
            found          <= 1'b0;
            found_position <= '0;
            count          <= COUNT_W'(count_next);
            status         <= imm_status;
          end
          if (go_rd) begin
            state <= S_RD;
          end
          if (go_scan) begin
            state     <= S_SCAN;
            key       <= word_in;
            scan_addr <= front_inc;
            scan_pos  <= '0;
          end
        end
        S_RD: begin
          state          <= S_IDLE;
          done           <= 1'b1;
          data_out       <= rd_ext;
          found          <= 1'b0;
          found_position <= '0;
          count          <= COUNT_W'(element_count);
          status         <= ST_OK;
        end
        S_SCAN: begin
          if (hit || last) begin
            state          <= S_IDLE;
            done           <= 1'b1;
            data_out       <= '0;
            found          <= hit;
            found_position <= hit ? POS_W'(scan_pos) : '0;
            count          <= COUNT_W'(element_count);
            status         <= ST_OK;
          end else begin
            scan_addr <= wrap({1'b0, scan_addr} + (AW + 1)'(1));
            scan_pos  <= scan_pos + CW'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign busy = (state != S_IDLE);

  // checks
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result beat while busy");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    element_count <= DEPTH_C)
    else $error("element count above depth");

  a_rd_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD) |=> done)
    else $error("read did not return a result");

  a_push_count: assert property (@(posedge clk) disable iff (rst)
    (accept && (kind == K_PUSH_FRONT || kind == K_PUSH_BACK) && !is_full)
    |=> (element_count == $past(element_count) + CW'(1)))
    else $error("push did not grow the queue");

endmodule
